[rtl/core/slctu_pkg.sv]
package slctu_pkg;

    // Table geometry defaults
    localparam int MAX_TILE_COLUMNS_DEF = 32;
    localparam int MAX_TILE_ROWS_DEF    = 32;

    // Field widths
    localparam int VAL_W      = 10;
    localparam int VAL_MAX    = 1023;
    localparam int COLS_W     = 6;
    localparam int IDX_W      = 5;
    localparam int FIRST_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int POS_W      = 21;
    localparam int RES_W      = 22;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;

    // Shared divider: 20-bit dividend, 10-bit divisor
    localparam int DIV_NW = 20;
    localparam int DIV_DW = 10;

    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ROW   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH    = 1'b1;

    localparam logic [RES_W-2:0] RESULT_MAX = 21'h1FFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_PRE_RD,
        ST_PRE_ACC,
        ST_FETCH,
        ST_MUL,
        ST_CMP,
        ST_DIV_OFF,
        ST_MULA,
        ST_ADD,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/slctu_div.sv]
module slctu_div import slctu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient,
    output logic [DIV_DW-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;

    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/core/slice_ctu_address_locator_core.sv]
// A table write leaves the block idle, so it stays ready for the next word.
// A query runs a divide for the first tile's position, a prefix-sum pass over both tables,
// a table read, area multiply and accumulate per tile walked, and a second divide.
// One query in flight; a finished result waits in the output register.
// Reset (synchronous, active low) marks every table entry unwritten, so it reads as zero, and sets both registers to 1.
module slice_ctu_address_locator_core import slctu_pkg::*; #(
    parameter int MAX_TILE_COLUMNS = MAX_TILE_COLUMNS_DEF,
    parameter int MAX_TILE_ROWS    = MAX_TILE_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [4:0] table_index, [14:5] table_value, [24:15] first_tile,
    // [35:25] tile_count, [56:36] ctu_position, [63:57] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [21:0] result_value, [23:22] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] is_count
    output logic [0:0]            o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CA   = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
    localparam int RA   = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int MAXX = (MAX_TILE_COLUMNS > MAX_TILE_ROWS) ? MAX_TILE_COLUMNS : MAX_TILE_ROWS;
    localparam int IW   = $clog2(MAXX + 1);
    localparam int XW   = $clog2(MAX_TILE_COLUMNS * VAL_MAX + 1);
    localparam int YW   = $clog2(MAX_TILE_ROWS * VAL_MAX + 1);
    localparam int PW   = YW + VAL_W;
    localparam int SW   = ((PW > XW) ? PW : XW) + 1;
    localparam int TY_W = FIRST_W;
    localparam int OFF_W = POS_W - 1;

    // ---------------- input field split ----------------
    logic [REQ_W-1:0]   w_req;
    logic [IDX_W-1:0]   w_tidx;
    logic [VAL_W-1:0]   w_tval;
    logic [FIRST_W-1:0] w_first;
    logic [COUNT_W-1:0] w_tcount;
    logic [POS_W-1:0]   w_pos;

    assign w_req    = i_s_axis_tuser;
    assign w_tidx   = i_s_axis_tdata[4:0];
    assign w_tval   = i_s_axis_tdata[14:5];
    assign w_first  = i_s_axis_tdata[24:15];
    assign w_tcount = i_s_axis_tdata[35:25];
    assign w_pos    = i_s_axis_tdata[56:36];

    // ---------------- configuration ----------------
    logic [COLS_W-1:0] r_cols;
    logic [VAL_W-1:0]  r_pw;
    logic [COLS_W-1:0] w_cols_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_W'(1);
            r_pw   <= VAL_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TILE_COLUMNS: r_cols <= i_cfg_data[COLS_W-1:0];
                CFG_PIC_WIDTH:    r_pw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cols_eff = (r_cols == '0) ? COLS_W'(1) : r_cols;

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic               r_want;
    logic [OFF_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_left;
    logic [COLS_W-1:0]  r_tx;
    logic [TY_W-1:0]    r_ty;
    logic [IW-1:0]      r_i;
    logic [XW-1:0]      r_minx;
    logic [YW-1:0]      r_miny;
    logic [RES_W-2:0]   r_total;
    logic [VAL_W-1:0]   r_w;
    logic [VAL_W-1:0]   r_h;
    logic [2*VAL_W-1:0] r_area;
    logic [YW-1:0]      r_yrow;
    logic [XW-1:0]      r_xcol;
    logic [PW-1:0]      r_prod;
    logic [RES_W-1:0]   r_res;
    logic               r_res_cnt;

    logic               r_out_v;
    logic [RES_W-1:0]   r_out_res;
    logic               r_out_cnt;

    // ---------------- shared divider ----------------
    logic              w_div_start;
    logic [DIV_NW-1:0] w_div_a;
    logic [DIV_DW-1:0] w_div_b;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_div_quo;
    logic [DIV_DW-1:0] w_div_rem;

    slctu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // ---------------- table memories ----------------
    logic                        w_s_acc;
    logic                        w_query;
    logic                        w_col_we, w_row_we;
    logic [CA-1:0]               w_col_wa, w_col_ra;
    logic [RA-1:0]               w_row_wa, w_row_ra;
    logic [VAL_W-1:0]            mem_col [MAX_TILE_COLUMNS];
    logic [VAL_W-1:0]            mem_row [MAX_TILE_ROWS];
    logic [MAX_TILE_COLUMNS-1:0] r_col_vld;
    logic [MAX_TILE_ROWS-1:0]    r_row_vld;
    logic [VAL_W-1:0]            r_col_q, r_row_q;
    logic                        r_col_qv, r_row_qv;
    logic [VAL_W-1:0]            w_col_d, w_row_d;

    assign w_s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_query  = w_s_acc && (w_req == REQ_QUERY);
    assign w_col_we = w_s_acc && (w_req == REQ_COL) && (32'(w_tidx) < MAX_TILE_COLUMNS);
    assign w_row_we = w_s_acc && (w_req == REQ_ROW) && (32'(w_tidx) < MAX_TILE_ROWS);
    assign w_col_wa = CA'(w_tidx);
    assign w_row_wa = RA'(w_tidx);
    assign w_col_ra = (r_state == ST_PRE_RD) ? CA'(r_i) : CA'(r_tx);
    assign w_row_ra = (r_state == ST_PRE_RD) ? RA'(r_i) : RA'(r_ty);

    // writes happen only while idle, so no read ever races a write to the same entry
    always_ff @(posedge i_clk) begin
        if (w_col_we) begin
            mem_col[w_col_wa] <= w_tval;
        end
        if (w_row_we) begin
            mem_row[w_row_wa] <= w_tval;
        end
        r_col_q <= mem_col[w_col_ra];
        r_row_q <= mem_row[w_row_ra];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
            r_row_vld <= '0;
            r_col_qv  <= 1'b0;
            r_row_qv  <= 1'b0;
        end else begin
            if (w_col_we) begin
                r_col_vld[w_col_wa] <= 1'b1;
            end
            if (w_row_we) begin
                r_row_vld[w_row_wa] <= 1'b1;
            end
            r_col_qv <= r_col_vld[w_col_ra];
            r_row_qv <= r_row_vld[w_row_ra];
        end
    end

    assign w_col_d = r_col_qv ? r_col_q : '0;
    assign w_row_d = r_row_qv ? r_row_q : '0;

    // ---------------- walk datapath terms ----------------
    logic             w_pre_x, w_pre_y;
    logic             w_walk_end;
    logic             w_skip;
    logic             w_wrap;
    logic [RES_W-1:0] w_sum;
    logic [RES_W-2:0] w_total_sat;
    logic             w_hit;
    logic [SW-1:0]    w_addr_sum;
    logic [RES_W-2:0] w_addr_sat;
    logic             w_out_load;

    assign w_pre_x     = (32'(r_i) < 32'(r_tx)) && (32'(r_i) < MAX_TILE_COLUMNS);
    assign w_pre_y     = (32'(r_i) < 32'(r_ty)) && (32'(r_i) < MAX_TILE_ROWS);
    assign w_walk_end  = (r_left == '0) || !(32'(r_ty) < MAX_TILE_ROWS);
    assign w_skip      = !(32'(r_tx) < MAX_TILE_COLUMNS);
    assign w_wrap      = ({1'b0, r_tx} + 7'd1) >= {1'b0, w_cols_eff};
    assign w_sum       = {1'b0, r_total} + RES_W'(r_area);
    assign w_total_sat = (w_sum > {1'b0, RESULT_MAX}) ? RESULT_MAX : w_sum[RES_W-2:0];
    assign w_hit       = !r_want && ({2'b00, r_pos} < w_sum);
    assign w_addr_sum  = SW'(r_prod) + SW'(r_xcol);
    assign w_addr_sat  = (w_addr_sum > SW'(RESULT_MAX)) ? RESULT_MAX : w_addr_sum[RES_W-2:0];
    assign w_out_load  = (r_state == ST_EMIT) && (!r_out_v || i_m_axis_tready);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_query) n_state = ST_DIV_START;
            ST_DIV_START: if (w_div_done) n_state = ST_PRE_RD;
            ST_PRE_RD:    n_state = (w_pre_x || w_pre_y) ? ST_PRE_ACC : ST_FETCH;
            ST_PRE_ACC:   n_state = ST_PRE_RD;
            ST_FETCH:     n_state = w_walk_end ? ST_EMIT : ST_MUL;
            ST_MUL:       n_state = ST_CMP;
            ST_CMP:       n_state = w_hit ? ST_DIV_OFF : ST_FETCH;
            ST_DIV_OFF:   if (w_div_done) n_state = ST_MULA;
            ST_MULA:      n_state = ST_ADD;
            ST_ADD:       n_state = ST_EMIT;
            ST_EMIT:      if (w_out_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_div_a         = DIV_NW'(r_pos - r_total[OFF_W-1:0]);
        w_div_b         = r_w;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_div_start     = w_query;
                w_div_a         = DIV_NW'(w_first);
                w_div_b         = DIV_DW'(w_cols_eff);
            end
            ST_CMP: begin
                w_div_start = w_hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- walk registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    r_pos   <= w_pos[OFF_W-1:0];
                    r_want  <= w_pos[POS_W-1];
                    r_left  <= w_tcount;
                    r_minx  <= '0;
                    r_miny  <= '0;
                    r_total <= '0;
                    r_i     <= '0;
                end
            end
            ST_DIV_START: begin
                if (w_div_done) begin
                    r_tx <= COLS_W'(w_div_rem);
                    r_ty <= TY_W'(w_div_quo);
                end
            end
            ST_PRE_ACC: begin
                if (w_pre_x) begin
                    r_minx <= r_minx + XW'(w_col_d);
                end
                if (w_pre_y) begin
                    r_miny <= r_miny + YW'(w_row_d);
                end
                r_i <= r_i + IW'(1);
            end
            ST_FETCH: begin
                if (w_walk_end) begin
                    r_res     <= r_want ? {1'b0, r_total} : '1;
                    r_res_cnt <= r_want;
                end
            end
            ST_MUL: begin
                // columns beyond the table hold no CTUs
                r_w    <= w_skip ? '0 : w_col_d;
                r_h    <= w_row_d;
                r_area <= w_skip ? '0 : w_col_d * w_row_d;
            end
            ST_CMP: begin
                if (!w_hit) begin
                    r_total <= w_total_sat;
                    r_left  <= r_left - COUNT_W'(1);
                    if (w_wrap) begin
                        r_tx   <= '0;
                        r_minx <= '0;
                        r_ty   <= r_ty + TY_W'(1);
                        r_miny <= r_miny + YW'(r_h);
                    end else begin
                        r_tx   <= r_tx + COLS_W'(1);
                        r_minx <= r_minx + XW'(r_w);
                    end
                end
            end
            ST_DIV_OFF: begin
                // quotient stays below the tile height
                if (w_div_done) begin
                    r_yrow <= r_miny + YW'(w_div_quo[VAL_W-1:0]);
                    r_xcol <= r_minx + XW'(w_div_rem);
                end
            end
            ST_MULA: begin
                r_prod <= PW'(r_yrow * r_pw);
            end
            ST_ADD: begin
                r_res     <= {1'b0, w_addr_sat};
                r_res_cnt <= 1'b0;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_res <= r_res;
            r_out_cnt <= r_res_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {2'b00, r_out_res};
    assign o_m_axis_tuser  = r_out_cnt;

    // ---------------- assertions ----------------
    a_row_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (32'(r_ty) < MAX_TILE_ROWS))
        else $error("tile row beyond table reached area stage");

    a_div_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_START || r_state == ST_DIV_OFF))
        else $error("divider finished outside a divide state");

    a_hit_nonzero_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && w_hit) |-> (r_w != '0))
        else $error("address divide started with zero tile width");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_v && r_state == ST_IDLE))
        else $error("result word not loaded into output register");

endmodule

[test/slice_ctu_address_locator_core_tb.sv]
`timescale 1ns / 1ps

module slice_ctu_address_locator_core_tb;
    import slctu_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_COUNT  = 21'h1FFFFF;  // -1: ask for the CTU count
    localparam logic [POS_W-1:0] POS_MOST_NEG = 21'h100000;
    localparam logic [RES_W-1:0] NO_CTU     = 22'h3FFFFF;  // -1: position past the slice
    localparam logic [RES_W-1:0] SAT_VALUE  = {1'b0, RESULT_MAX};
    localparam int NUM_DIRECTED    = 22;
    localparam int NUM_PHASES      = 8;
    localparam int RANDOM_PHASE    = 5;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 64;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLDOFF_CYCLES  = 1500;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             is_count;
    } result_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   val;
        logic [FIRST_W-1:0] first;
        logic [COUNT_W-1:0] ntiles;
        logic [POS_W-1:0]   pos;
        logic               fixed;      // expected result typed in below
        logic [RES_W-1:0]   exp_value;
        logic               exp_count;
    } word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [REQ_W-1:0]      i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    slice_ctu_address_locator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow copy of the block's registers and tables
    logic [COLS_W-1:0] tile_cols = 6'd1;
    logic [VAL_W-1:0]  pic_width = 10'd1;
    logic [VAL_W-1:0]  col_widths [MAX_TILE_COLUMNS_DEF];
    logic [VAL_W-1:0]  row_heights [MAX_TILE_ROWS_DEF];

    result_t pending_results [$];
    int      error_count = 0;
    int      results_seen = 0;
    int      burst_left = 0;

    word_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    POS_COUNT,    1'b1, 22'd0,   1'b1},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    21'd0,        1'b1, NO_CTU,  1'b0},
        '{REQ_UNUSED, 5'd31, 10'd1023, 10'd1023, 11'd1024, POS_COUNT,    1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd0,    POS_COUNT,    1'b1, 22'd0,   1'b1},
        '{REQ_COL,    5'd0,  10'd1023, 10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_ROW,    5'd0,  10'd1023, 10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    POS_COUNT,    1'b1, 22'd1046529, 1'b1},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    21'h0FFFFF,   1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    21'd1046528,  1'b0, 22'd0,   1'b0},
        '{REQ_ROW,    5'd1,  10'd1023, 10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_ROW,    5'd2,  10'd1023, 10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd3,    POS_COUNT,    1'b1, SAT_VALUE, 1'b1},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1024, POS_COUNT,    1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd1023, 11'd1024, 21'd5,        1'b1, NO_CTU,  1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd1023, 11'd1024, POS_MOST_NEG, 1'b1, 22'd0,   1'b1},
        '{REQ_COL,    5'd31, 10'd1,    10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_ROW,    5'd31, 10'd1,    10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd31,   11'd1,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd2,    11'd1,    21'd1000000,  1'b0, 22'd0,   1'b0},
        '{REQ_COL,    5'd1,  10'd0,    10'd0,    11'd0,    21'd0,        1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd2,    21'd1046529,  1'b0, 22'd0,   1'b0},
        '{REQ_QUERY,  5'd0,  10'd0,    10'd0,    11'd1,    21'd1,        1'b0, 22'd0,   1'b0}
    };

    // tile_columns data (upper bits are don't-care), picture width
    logic [CFG_DATA_W-1:0] phase_cols  [NUM_PHASES] = '{10'd4, 10'd0, 10'd32, 10'h3FF,
                                                        10'd1, 10'd3, 10'd2, 10'h2C8};
    logic [CFG_DATA_W-1:0] phase_width [NUM_PHASES] = '{10'd10, 10'd1023, 10'd0, 10'd1023,
                                                        10'd1, 10'd5, 10'd1023, 10'd37};

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("slice_ctu_address_locator_core_tb failed");
        $finish;
    end

    function automatic logic [RES_W-1:0] clip_result(input longint unsigned v);
        return (v > longint'(RESULT_MAX)) ? SAT_VALUE : RES_W'(v);
    endfunction

    // Walk the slice tile by tile, summing areas until the position falls inside one (or to the end for a count)
    function automatic result_t locate_ctu(input logic [FIRST_W-1:0] first,
                                           input logic [COUNT_W-1:0] ntiles,
                                           input logic [POS_W-1:0] pos);
        result_t r;
        int unsigned cols, t, tx, ty;
        longint unsigned total, area, min_x, min_y, w, h, off, addr, p;
        bit found;
        cols = (tile_cols == 0) ? 1 : tile_cols;
        total = 0;
        found = 0;
        p = pos;
        r = '0;
        for (t = first; t < first + ntiles && !found; t++) begin
            tx = t % cols;
            ty = t / cols;
            if (tx < MAX_TILE_COLUMNS_DEF && ty < MAX_TILE_ROWS_DEF) begin
                min_x = 0;
                min_y = 0;
                for (int i = 0; i < ty; i++) min_y += row_heights[i];
                for (int i = 0; i < tx; i++) min_x += col_widths[i];
                w = col_widths[tx];
                h = row_heights[ty];
                area = w * h;
                if (!pos[POS_W-1] && p < total + area) begin
                    off = p - total;
                    addr = (min_y + off / w) * pic_width + min_x + off % w;
                    r.value = clip_result(addr);
                    r.is_count = 1'b0;
                    found = 1;
                end else begin
                    total += area;
                end
            end
        end
        if (!found) begin
            if (pos[POS_W-1]) begin
                r.value = clip_result(total);
                r.is_count = 1'b1;
            end else begin
                r.value = NO_CTU;
                r.is_count = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = 40;
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Offer one word; tvalid is only lowered during a gap before it
    task automatic send_word(input word_t w);
        int unsigned gap;
        result_t fixed_res;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, w.pos, w.ntiles, w.first, w.val, w.idx};
        i_s_axis_tuser  <= w.req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (w.req == REQ_QUERY) begin
            fixed_res.value    = w.exp_value;
            fixed_res.is_count = w.exp_count;
            pending_results.push_back(w.fixed ? fixed_res : locate_ctu(w.first, w.ntiles, w.pos));
        end else if (w.req == REQ_COL) begin
            col_widths[w.idx] = w.val;
        end else if (w.req == REQ_ROW) begin
            row_heights[w.idx] = w.val;
        end
    endtask

    task automatic send_random_word();
        word_t w;
        result_t tally;
        int unsigned r, ceff, total, top;
        w = '0;
        w.idx    = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        w.first  = FIRST_W'($urandom);
        w.ntiles = COUNT_W'($urandom);
        w.pos    = POS_W'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) w.val = '0;
        else if (r == 1) w.val = VAL_W'(VAL_MAX);
        else if (r == 2) w.val = VAL_W'($urandom);
        else w.val = VAL_W'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 15) begin
            w.req = REQ_COL;
        end else if (r < 30) begin
            w.req = REQ_ROW;
        end else if (r < 34) begin
            w.req = REQ_UNUSED;
        end else begin
            w.req = REQ_QUERY;
            ceff = (tile_cols == 0) ? 1 : tile_cols;
            r = $urandom_range(0, 9);
            top = (ceff * 32 + 8 > 1023) ? 1023 : ceff * 32 + 8;
            if (r < 6) w.first = FIRST_W'($urandom_range(0, 40));
            else if (r < 9) w.first = FIRST_W'($urandom_range(0, top));
            // long slices are slow, so keep them rare
            r = $urandom_range(0, 99);
            if (r < 2) w.ntiles = 11'd1024;
            else if (r < 4) w.ntiles = COUNT_W'($urandom_range(100, 1023));
            else if (r < 10) w.ntiles = '0;
            else w.ntiles = COUNT_W'($urandom_range(1, 12));
            tally = locate_ctu(w.first, w.ntiles, POS_COUNT);
            total = tally.value;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                w.pos = POS_COUNT;
            end else if (r < 15) begin
                w.pos = {1'b1, 20'($urandom)};
            end else if (r < 85 && total > 0) begin
                top = (total - 1 > 1048575) ? 1048575 : total - 1;
                w.pos = POS_W'($urandom_range(0, top));
            end else if (r < 90 && total <= 1048575) begin
                w.pos = POS_W'(total);
            end else begin
                w.pos = {1'b0, 20'($urandom)};
            end
        end
        send_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TILE_COLUMNS) tile_cols = data[COLS_W-1:0];
        else pic_width = data;
    endtask

    // Waits until the block is idle: all results back and the pipe settled
    task automatic program_regs(input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] width);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_TILE_COLUMNS, cols);
            write_reg(CFG_PIC_WIDTH, width);
        end else begin
            write_reg(CFG_PIC_WIDTH, width);
            write_reg(CFG_TILE_COLUMNS, cols);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int ph;
        foreach (col_widths[k]) col_widths[k] = '0;
        foreach (row_heights[k]) row_heights[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[k]) send_word(directed_rows[k]);
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == RANDOM_PHASE)
                program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            else
                program_regs(phase_cols[ph], phase_width[ph]);
            repeat (ITEMS_PER_PHASE) send_random_word();
        end
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("slice_ctu_address_locator_core_tb passed");
        end else begin
            $display("slice_ctu_address_locator_core_tb failed");
        end
        $finish;
    end

    // Result side: check each accepted word, and drive tready with random stalls
    result_t oldest;
    int  hold_left = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    int unsigned rdy_roll;
    logic rdy;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: result_value %0d is_count %0d",
                       $signed(o_m_axis_tdata[RES_W-1:0]), o_m_axis_tuser[0]);
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_m_axis_tdata[RES_W-1:0] !== oldest.value) begin
                    $error("result_value: expected %0d, got %0d", $signed(oldest.value),
                           $signed(o_m_axis_tdata[RES_W-1:0]));
                    error_count++;
                end
                if (o_m_axis_tuser[0] !== oldest.is_count) begin
                    $error("is_count: expected %0d, got %0d", oldest.is_count,
                           o_m_axis_tuser[0]);
                    error_count++;
                end
            end
            // long hold-off so the block backs up into its input
            if (results_seen == 60 || results_seen == 300) hold_left = HOLDOFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            rdy = 1'b1;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 2) begin
                calm_left = $urandom_range(50, 200);
                rdy = 1'b1;
            end else if (rdy_roll < 70) begin
                rdy = 1'b1;
            end else if (rdy_roll < 95) begin
                stall_left = $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                stall_left = $urandom_range(20, 80);
                rdy = 1'b0;
            end
        end
        i_m_axis_tready <= rdy;
    end

endmodule
